// ===== src/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg: shared types and constants of the WAV RIFF chunk parser
// Transaction structs, parser phase codes, tag constants and the INFO tag lookup.
// ----------------------------------------------------------------------------
package wrp_pkg;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [31:0] file_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [2:0]  tag_index;
      logic [2:0]  status;
      logic [31:0] data_size;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_HDR, OP_SKIP, OP_DATA, OP_LIST, OP_PAD, OP_IDLE
   } outer_type;

   typedef enum logic [2:0] {
      LP_TYPE, LP_EHDR, LP_PAY, LP_PAD, LP_SKIP
   } list_type;

   localparam logic [1:0] KIND_PCM    = 2'd0;
   localparam logic [1:0] KIND_META   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_BAD_TAG   = 3'd2;
   localparam logic [2:0] ST_NOT_PCM   = 3'd3;
   localparam logic [2:0] ST_NO_DATA   = 3'd4;
   localparam logic [2:0] ST_TRUNCATED = 3'd5;

   localparam int unsigned HEADER_BYTES = 44;

   localparam logic [31:0] ID_RIFF = 32'h52494646;
   localparam logic [31:0] ID_WAVE = 32'h57415645;
   localparam logic [31:0] ID_DATA = 32'h64617461;
   localparam logic [31:0] ID_LIST = 32'h4C495354;
   localparam logic [31:0] ID_INFO = 32'h494E464F;

   localparam logic [3:0] TAG_NONE = 4'd8;

   localparam logic [31:0] INFO_TAGS [8] = '{
      32'h49415254, 32'h49434D54, 32'h49434F50, 32'h49435244,
      32'h49454E47, 32'h49534654, 32'h494E414D, 32'h4953424A
   };

   // first matching tag wins; TAG_NONE when nothing matches
   function automatic logic [3:0] tag_lookup(input logic [31:0] id);
      logic [3:0] res;
      res = TAG_NONE;
      for (int i = 7; i >= 0; i--) begin
         if (id == INFO_TAGS[i]) begin
            res = 4'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== src/wrp_core.sv =====
// ----------------------------------------------------------------------------
// wrp_core: per-byte parser state and result generation
// Updates the chunk walker for one registered byte and forms up to two results.
// ----------------------------------------------------------------------------
module wrp_core #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  wrp_pkg::req_type item,
   output logic [1:0]      push_count,
   output wrp_pkg::rsp_type res0,
   output wrp_pkg::rsp_type res1
);
   import wrp_pkg::*;

   localparam int LW = LENGTH_WIDTH;

   logic [LW-1:0] pos_ff, pos_in;
   logic          fmt_ff, fmt_in;
   outer_type     outer_ff, outer_in;
   logic [31:0]   id_ff, id_in;
   logic [31:0]   csize_ff, csize_in;
   logic [31:0]   cleft_ff, cleft_in;
   list_type      lphase_ff, lphase_in;
   logic [31:0]   loff_ff, loff_in;
   logic [31:0]   eid_ff, eid_in;
   logic [31:0]   eleft_ff, eleft_in;
   logic [3:0]    etag_ff, etag_in;
   logic          fin_ff, fin_in;
   logic [3:0]    chc_ff, chc_in;
   logic [3:0]    ehc_ff, ehc_in;
   logic          eodd_ff, eodd_in;

   logic [LW-1:0] p, fl;
   logic [7:0]    b;
   logic [31:0]   o;
   logic          byte_v, st_v;
   logic [1:0]    byte_kind;
   logic [2:0]    byte_tag, st_code;
   logic [31:0]   st_size;
   rsp_type       byte_r, st_r;

   always_comb begin
      pos_in = pos_ff; fmt_in = fmt_ff; outer_in = outer_ff; id_in = id_ff;
      csize_in = csize_ff; cleft_in = cleft_ff; lphase_in = lphase_ff; loff_in = loff_ff;
      eid_in = eid_ff; eleft_in = eleft_ff; etag_in = etag_ff; fin_in = fin_ff;
      chc_in = chc_ff; ehc_in = ehc_ff; eodd_in = eodd_ff;
      byte_v = 1'b0; byte_kind = KIND_PCM; byte_tag = '0;
      st_v = 1'b0; st_code = ST_OK; st_size = '0;
      b = item.data_byte;
      fl = item.file_length[LW-1:0];
      o = '0;

      // restart on the first byte of a file
      if (item.first_byte) begin
         pos_in = '0; fmt_in = 1'b0; outer_in = OP_HDR; id_in = '0; csize_in = '0;
         cleft_in = '0; lphase_in = LP_TYPE; loff_in = '0; eid_in = '0; eleft_in = '0;
         etag_in = TAG_NONE; fin_in = 1'b0; chc_in = '0; ehc_in = '0; eodd_in = 1'b0;
      end

      p = pos_in;
      if (pos_in != '1) begin
         pos_in = pos_in + 1'b1;
      end

      if (!fin_in) begin
         if (p == '0 && 32'(fl) < 32'(HEADER_BYTES)) begin
            st_v = 1'b1; st_code = ST_SHORT; fin_in = 1'b1;
         end else if (p < LW'(12)) begin
            id_in = {id_in[23:0], b};
            if ((p == LW'(3) && id_in != ID_RIFF) || (p == LW'(11) && id_in != ID_WAVE)) begin
               st_v = 1'b1; st_code = ST_BAD_TAG; fin_in = 1'b1;
            end
         end else begin
            unique case (outer_in)
               OP_HDR: begin
                  if (chc_in < 4'd4) id_in = {id_in[23:0], b};
                  else csize_in = {b, csize_in[31:8]};
                  chc_in = chc_in + 1'b1;
                  if (chc_in == 4'd8) begin
                     chc_in = '0;
                     cleft_in = csize_in;
                     if (({1'b0, p} + 1'b1) >= {1'b0, fl}) begin
                        outer_in = OP_IDLE;
                     end else if (p == LW'(19) && (id_in == ID_DATA || id_in == ID_LIST)) begin
                        st_v = 1'b1; st_code = ST_TRUNCATED; fin_in = 1'b1;
                     end else if (id_in == ID_DATA) begin
                        if (csize_in == '0) begin
                           st_v = 1'b1; st_code = ST_OK; fin_in = 1'b1;
                        end else begin
                           outer_in = OP_DATA;
                        end
                     end else if (csize_in == '0) begin
                        outer_in = csize_in[0] ? OP_PAD : OP_HDR;
                     end else if (id_in == ID_LIST) begin
                        outer_in = OP_LIST; lphase_in = LP_TYPE; loff_in = '0; eid_in = '0;
                     end else begin
                        outer_in = OP_SKIP;
                     end
                  end
               end
               OP_SKIP: begin
                  cleft_in = cleft_in - 1'b1;
                  if (cleft_in == '0) begin
                     outer_in = csize_in[0] ? OP_PAD : OP_HDR; chc_in = '0;
                  end
               end
               OP_DATA: begin
                  byte_v = 1'b1; byte_kind = KIND_PCM;
                  cleft_in = cleft_in - 1'b1;
                  if (cleft_in == '0) begin
                     st_v = 1'b1; st_code = ST_OK; st_size = csize_in; fin_in = 1'b1;
                  end
               end
               OP_LIST: begin
                  o = loff_in;
                  loff_in = loff_in + 1'b1;
                  unique case (lphase_in)
                     LP_TYPE: begin
                        eid_in = {eid_in[23:0], b};
                        if (o == 32'd3) begin
                           lphase_in = (eid_in == ID_INFO) ? LP_EHDR : LP_SKIP;
                           ehc_in = '0;
                        end
                     end
                     LP_EHDR: begin
                        if (ehc_in == '0 && ({1'b0, o} + 33'd8) >= {1'b0, csize_in}) begin
                           lphase_in = LP_SKIP;
                        end else begin
                           if (ehc_in < 4'd4) eid_in = {eid_in[23:0], b};
                           else eleft_in = {b, eleft_in[31:8]};
                           ehc_in = ehc_in + 1'b1;
                           if (ehc_in == 4'd8) begin
                              ehc_in = '0;
                              // entry end is o + 1 + size
                              if (eleft_in == '0 || ({2'b0, o} + 34'd1 + {2'b0, eleft_in})
                                    > {2'b0, csize_in}) begin
                                 lphase_in = LP_SKIP;
                              end else begin
                                 etag_in = tag_lookup(eid_in);
                                 eodd_in = eleft_in[0];
                                 lphase_in = LP_PAY;
                              end
                           end
                        end
                     end
                     LP_PAY: begin
                        if (etag_in != TAG_NONE) begin
                           byte_v = 1'b1; byte_kind = KIND_META; byte_tag = etag_in[2:0];
                        end
                        eleft_in = eleft_in - 1'b1;
                        if (eleft_in == '0) begin
                           lphase_in = eodd_in ? LP_PAD : LP_EHDR; ehc_in = '0;
                        end
                     end
                     LP_PAD: begin
                        lphase_in = LP_EHDR; ehc_in = '0;
                     end
                     default: ;
                  endcase
                  cleft_in = cleft_in - 1'b1;
                  if (cleft_in == '0) begin
                     outer_in = csize_in[0] ? OP_PAD : OP_HDR; chc_in = '0;
                  end
               end
               OP_PAD: begin
                  outer_in = OP_HDR; chc_in = '0;
               end
               default: ;
            endcase
            if (!fin_in && p == LW'(20) && b == 8'd1) fmt_in = 1'b1;
            if (!fin_in && p == LW'(21) && !(fmt_in && b == 8'd0)) begin
               st_v = 1'b1; st_code = ST_NOT_PCM; fin_in = 1'b1;
            end
         end
         if (!fin_in && fl != '0 && p == fl - 1'b1) begin
            st_v = 1'b1; fin_in = 1'b1;
            if (outer_in == OP_DATA) begin
               st_code = ST_TRUNCATED; st_size = csize_in;
            end else begin
               st_code = ST_NO_DATA;
            end
         end
      end
   end

   always_comb begin
      byte_r = '{kind: byte_kind, out_byte: b, tag_index: byte_tag, status: ST_OK,
                 data_size: '0, last: !st_v};
      st_r = '{kind: KIND_STATUS, out_byte: '0, tag_index: '0, status: st_code,
               data_size: st_size, last: 1'b1};
      res0 = byte_v ? byte_r : st_r;
      res1 = st_r;
      push_count = step ? ({1'b0, byte_v} + {1'b0, st_v}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; fmt_ff <= 1'b0; outer_ff <= OP_HDR; id_ff <= '0; csize_ff <= '0;
         cleft_ff <= '0; lphase_ff <= LP_TYPE; loff_ff <= '0; eid_ff <= '0;
         eleft_ff <= '0; etag_ff <= TAG_NONE; fin_ff <= 1'b0; chc_ff <= '0;
         ehc_ff <= '0; eodd_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in; fmt_ff <= fmt_in; outer_ff <= outer_in; id_ff <= id_in;
         csize_ff <= csize_in; cleft_ff <= cleft_in; lphase_ff <= lphase_in;
         loff_ff <= loff_in; eid_ff <= eid_in; eleft_ff <= eleft_in; etag_ff <= etag_in;
         fin_ff <= fin_in; chc_ff <= chc_in; ehc_ff <= ehc_in; eodd_ff <= eodd_in;
      end
   end

endmodule

// ===== src/wrp_fifo.sv =====
// ----------------------------------------------------------------------------
// wrp_fifo: result queue
// Four-entry queue that takes up to two results per cycle and drains one.
// ----------------------------------------------------------------------------
module wrp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  wrp_pkg::rsp_type push0,
   input  wrp_pkg::rsp_type push1,
   input  logic             pop,
   output logic             not_empty,
   output wrp_pkg::rsp_type head,
   output logic [2:0]       level
);
   import wrp_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] rd_ff, rd_in;
   logic [1:0] wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;

   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];
   assign level = cnt_ff;

   always_comb begin
      rd_in = rd_ff + {1'b0, pop};
      wr_in = wr_ff + push_count;
      cnt_in = cnt_ff + {1'b0, push_count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_ff + 2'd1] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== src/wav_riff_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// wav_riff_chunk_parser: streaming RIFF/WAVE chunk parser
// One file byte per transaction in; PCM bytes, INFO metadata bytes and one
// final status per file out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one file byte with first_byte and the file length. A
//   transaction moves when valid is high and stall is low. The byte lands in
//   an input register; the parser updates its state from that register and
//   writes zero, one or two results into a four-entry result queue.
//   rsp_* presents the queue head.
// Path: a byte is registered in the input register; its results are then
//   written into the result queue, whose head drives rsp_*.
// Throughput: one byte per cycle while each byte makes at most one result
//   and the receiver does not stall; a byte that makes two results (last data
//   byte plus status) queues an extra result for the single-result output port.
// Reset: clears the parser state and empties the queue. first_byte restarts
//   parsing for a new file.
// Receiver stall: the queue holds its results; once fewer than two slots are
//   free the parser stops; req_stall rises while a byte waits for it.
// ----------------------------------------------------------------------------
module wav_riff_chunk_parser #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wrp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wrp_pkg::rsp_type rsp_data
);
   import wrp_pkg::*;

   req_type    in_ff;
   logic       in_vld_ff, in_vld_in;
   logic       step;
   logic [1:0] push_count;
   rsp_type    res0, res1;
   logic [2:0] level;
   logic       pop;

   // advance only with room for two results
   assign step = in_vld_ff && (level <= 3'd2);
   assign req_stall = in_vld_ff && !step;
   assign pop = rsp_valid && !rsp_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && !req_stall) in_vld_in = 1'b1;
      else if (step) in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else in_vld_ff <= in_vld_in;
   end

   wrp_core #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_core (
      .clock(clock), .reset(reset), .step(step), .item(in_ff),
      .push_count(push_count), .res0(res0), .res1(res1)
   );

   wrp_fifo u_fifo (
      .clock(clock), .reset(reset), .push_count(push_count), .push0(res0),
      .push1(res1), .pop(pop), .not_empty(rsp_valid), .head(rsp_data), .level(level)
   );

   a_level_bound: assert property (@(posedge clock) disable iff (reset) level <= 3'd4)
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd0 |-> level <= 3'd2)
      else $error("push without room");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |-> rsp_data.last)
      else $error("status not last");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_vld_ff)
      else $error("stalled item lost");

endmodule

// ===== tb/wav_riff_chunk_parser_test.sv =====
// ----------------------------------------------------------------------------
// wav_riff_chunk_parser_test: self-checking bench for the WAV RIFF chunk parser
// Streams directed and random WAV files byte by byte, predicts every PCM,
// metadata and status result and compares them in order with the block output.
// ----------------------------------------------------------------------------
module wav_riff_chunk_parser_test;
   import wrp_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   wav_riff_chunk_parser i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // predictor state
   logic [31:0] pos;
   logic [2:0]  hdr_bits;
   outer_type   ophase;
   logic [31:0] cid;
   logic [31:0] csize;
   logic [31:0] cleft;
   list_type    lphase;
   logic [31:0] loff;
   logic [31:0] eid;
   logic [31:0] eleft;
   logic [3:0]  etag;
   logic        done_flag;
   int          chdr;
   int          ehdr;
   logic        eodd;

   rsp_type     pending_rsp[$];
   rsp_type     step_rsp[$];
   int          errors;
   logic        idle_en;
   byte unsigned file_bytes[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("wav_riff_chunk_parser_test: done, errors");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   function automatic void parser_clear();
      pos = 0; hdr_bits = 0; ophase = OP_HDR; cid = 0; csize = 0; cleft = 0;
      lphase = LP_TYPE; loff = 0; eid = 0; eleft = 0; etag = TAG_NONE;
      done_flag = 0; chdr = 0; ehdr = 0; eodd = 0;
   endfunction

   function automatic void push_rsp(input logic [1:0] k, input logic [7:0] b,
                                    input logic [2:0] t, input logic [2:0] s,
                                    input logic [31:0] sz);
      rsp_type r;
      r.kind = k; r.out_byte = b; r.tag_index = t; r.status = s;
      r.data_size = sz; r.last = 1'b0;
      step_rsp.push_back(r);
   endfunction

   function automatic void end_file(input logic [2:0] s, input logic [31:0] sz);
      push_rsp(KIND_STATUS, 8'd0, 3'd0, s, sz);
      done_flag = 1;
   endfunction

   function automatic void chunk_done();
      ophase = csize[0] ? OP_PAD : OP_HDR;
      chdr = 0;
   endfunction

   function automatic void info_byte(input logic [7:0] b);
      logic [31:0] o;
      logic [63:0] start;
      o = loff;
      loff++;
      case (lphase)
         LP_TYPE: begin
            eid = {eid[23:0], b};
            if (o == 3) begin
               lphase = (eid == ID_INFO) ? LP_EHDR : LP_SKIP;
               ehdr = 0;
            end
         end
         LP_EHDR: begin
            if (ehdr == 0 && {32'd0, o} + 8 >= {32'd0, csize}) begin
               lphase = LP_SKIP;
            end else begin
               if (ehdr < 4) eid = {eid[23:0], b};
               else eleft = {b, eleft[31:8]};
               ehdr++;
               if (ehdr == 8) begin
                  start = {32'd0, o} - 7;
                  ehdr = 0;
                  if (eleft == 0 || start + 8 + {32'd0, eleft} > {32'd0, csize}) begin
                     lphase = LP_SKIP;
                  end else begin
                     etag = TAG_NONE;
                     for (int i = 7; i >= 0; i--) if (eid == INFO_TAGS[i]) etag = 4'(i);
                     eodd = eleft[0];
                     lphase = LP_PAY;
                  end
               end
            end
         end
         LP_PAY: begin
            if (etag < TAG_NONE) push_rsp(KIND_META, b, etag[2:0], ST_OK, 32'd0);
            eleft--;
            if (eleft == 0) begin
               lphase = eodd ? LP_PAD : LP_EHDR;
               ehdr = 0;
            end
         end
         LP_PAD: begin
            lphase = LP_EHDR;
            ehdr = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void chunk_walk(input logic [31:0] p, input logic [7:0] b,
                                      input logic [31:0] fl);
      case (ophase)
         OP_HDR: begin
            if (chdr < 4) cid = {cid[23:0], b};
            else csize = {b, csize[31:8]};
            chdr++;
            if (chdr == 8) begin
               chdr = 0;
               cleft = csize;
               if ({32'd0, p} + 1 >= {32'd0, fl}) ophase = OP_IDLE;
               else if (p == 19 && (cid == ID_DATA || cid == ID_LIST))
                  end_file(ST_TRUNCATED, 32'd0);
               else if (cid == ID_DATA) begin
                  if (csize == 0) end_file(ST_OK, 32'd0);
                  else ophase = OP_DATA;
               end else if (csize == 0) chunk_done();
               else if (cid == ID_LIST) begin
                  ophase = OP_LIST; lphase = LP_TYPE; loff = 0; eid = 0;
               end else ophase = OP_SKIP;
            end
         end
         OP_SKIP: begin
            cleft--;
            if (cleft == 0) chunk_done();
         end
         OP_DATA: begin
            push_rsp(KIND_PCM, b, 3'd0, ST_OK, 32'd0);
            cleft--;
            if (cleft == 0) end_file(ST_OK, csize);
         end
         OP_LIST: begin
            info_byte(b);
            cleft--;
            if (cleft == 0) chunk_done();
         end
         OP_PAD: begin
            ophase = OP_HDR;
            chdr = 0;
         end
         default: ;
      endcase
   endfunction

   // predict the results of one file byte and queue them
   function automatic void parse_byte(input req_type rq);
      logic [31:0] p;
      logic [31:0] fl;
      logic [7:0]  b;
      b = rq.data_byte; fl = rq.file_length;
      step_rsp.delete();
      if (rq.first_byte) parser_clear();
      p = pos;
      if (pos != 32'hFFFFFFFF) pos++;
      if (!done_flag) begin
         if (p == 0 && fl < HEADER_BYTES) end_file(ST_SHORT, 32'd0);
         else if (p < 12) begin
            cid = {cid[23:0], b};
            if (p == 3) begin
               if (cid == ID_RIFF) hdr_bits[0] = 1;
               else end_file(ST_BAD_TAG, 32'd0);
            end else if (p == 11) begin
               if (cid == ID_WAVE) hdr_bits[1] = 1;
               else end_file(ST_BAD_TAG, 32'd0);
            end
         end else begin
            chunk_walk(p, b, fl);
            if (!done_flag && p == 20 && b == 1) hdr_bits[2] = 1;
            if (!done_flag && p == 21 && !(hdr_bits[2] && b == 0))
               end_file(ST_NOT_PCM, 32'd0);
         end
         if (!done_flag && fl != 0 && p == fl - 1) begin
            if (ophase == OP_DATA) end_file(ST_TRUNCATED, csize);
            else end_file(ST_NO_DATA, 32'd0);
         end
         if (step_rsp.size() > 0) step_rsp[step_rsp.size()-1].last = 1'b1;
         foreach (step_rsp[i]) pending_rsp.push_back(step_rsp[i]);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first, input logic [31:0] fl);
      req_type rq;
      if (idle_en && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      rq.data_byte = b; rq.first_byte = first; rq.file_length = fl;
      req_valid <= 1'b1;
      req_data  <= rq;
      // stall is stable mid-cycle; the transaction moves at the next edge with stall low
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      parse_byte(rq);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put_id(input logic [31:0] id);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(id[8*i +: 8]);
   endtask

   // RIFF, WAVE and a fmt chunk of 16 bytes with the given format code
   task automatic put_header(input logic [15:0] fmt);
      file_bytes.delete();
      put_id(ID_RIFF); put32(0); put_id(ID_WAVE);
      put_id(32'h666D7420); put32(16);
      file_bytes.push_back(fmt[7:0]); file_bytes.push_back(fmt[15:8]);
      for (int i = 0; i < 14; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_file(input logic [31:0] fl);
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0, fl);
   endtask

   task automatic put_rand(input int n);
      for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // receiver side: random stall bursts and in-order compare
   initial begin
      rsp_type want;
      rsp_type got;
      logic    take;
      int      hold;
      rsp_stall = 1'b0;
      hold = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // sample mid-cycle, act on the transaction at the next edge
         @(negedge clock);
         got = rsp_data;
         take = rsp_valid && !rsp_stall;
         @(posedge clock);
         if (take) begin
            if (pending_rsp.size() == 0) report("result with nothing expected");
            else begin
               want = pending_rsp.pop_front();
               if (got.kind != want.kind)
                  report($sformatf("kind %0d want %0d", got.kind, want.kind));
               if (got.out_byte != want.out_byte)
                  report($sformatf("byte %0h want %0h", got.out_byte, want.out_byte));
               if (got.tag_index != want.tag_index)
                  report($sformatf("tag %0d want %0d", got.tag_index, want.tag_index));
               if (got.status != want.status)
                  report($sformatf("status %0d want %0d", got.status, want.status));
               if (got.data_size != want.data_size)
                  report($sformatf("size %0h want %0h", got.data_size, want.data_size));
               if (got.last != want.last)
                  report($sformatf("last %0b want %0b", got.last, want.last));
            end
         end
         if (hold > 0) hold--;
         else if (idle_en && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 18);
         rsp_stall <= (hold > 0);
      end
   end

   task automatic test_header_errors();
      put_header(16'd1);
      send_file(43);                               // too short
      put_header(16'd1); file_bytes[2] = 8'h00;
      send_file(44);                               // bad RIFF
      put_header(16'd1); file_bytes[10] = 8'hFF;
      send_file(44);                               // bad WAVE
      put_header(16'd2);
      send_file(44);                               // not PCM
      put_header(16'h0101);
      send_file(44);                               // high byte of format set
      file_bytes.delete();
      put_id(ID_RIFF); put32(0); put_id(ID_WAVE); put_id(ID_DATA); put32(4); put_rand(30);
      send_file(44);                               // payload before format
      wait_drained();
   endtask

   task automatic test_data_paths();
      put_header(16'd1); put_id(ID_DATA); put32(0); put_rand(4);
      send_file(48);                               // empty data chunk
      put_header(16'd1); put_id(ID_DATA); put32(6); put_rand(6); put_rand(3);
      send_file(50);                               // data done, trailing bytes ignored
      put_header(16'd1); put_id(ID_DATA); put32(32'hFFFFFFFF); put_rand(5);
      send_file(49);                               // truncated data
      put_header(16'd1); put_id(32'h4A554E4B); put32(3); put_rand(4);
      send_file(48);                               // skipped odd chunk and pad, no data
      put_header(16'd1); put_rand(8);
      send_file(32'hFFFFFFFF);
      send_byte(8'hFF, 1'b1, 32'd0);               // zero length file
      wait_drained();
   endtask

   task automatic test_info_list();
      put_header(16'd1); put_id(ID_LIST); put32(27); put_id(ID_INFO);
      put_id(INFO_TAGS[7]); put32(3); put_rand(4);
      put_id(32'h58585858); put32(2); put_rand(2);
      put_rand(1);                                 // last list byte, list size odd
      put_id(ID_DATA); put32(2); put_rand(2);
      send_file(80);
      put_header(16'd1); put_id(ID_LIST); put32(3); put_rand(4);
      put_id(ID_DATA); put32(1); put_rand(1);
      send_file(54);                               // list too short
      wait_drained();
   endtask

   // well-formed files with random chunk content, plus some noise
   task automatic test_random_files(input int budget);
      int sent;
      int len;
      int n;
      int t;
      sent = 0;
      while (sent < budget) begin
         put_header(($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'd1);
         if ($urandom_range(0, 1)) begin
            put_id(ID_LIST);
            n = $urandom_range(0, 3);
            len = 4;
            for (int k = 0; k < n; k++) len += 8 + 2 * $urandom_range(1, 4);
            len += $urandom_range(0, 3);
            put32(len);
            put_id($urandom_range(0, 5) == 0 ? 32'($urandom) : ID_INFO);
            t = 4;
            for (int k = 0; k < n; k++) begin
               int es;
               es = $urandom_range(1, 7);
               put_id(($urandom_range(0, 4) == 0) ? 32'($urandom)
                      : INFO_TAGS[$urandom_range(0, 7)]);
               put32(es); put_rand(es + (es & 1));
               t += 8 + es + (es & 1);
            end
            if (t < len) put_rand(len - t);
            else while (t > len) begin void'(file_bytes.pop_back()); t--; end
            if (len & 1) put_rand(1);
         end
         if ($urandom_range(0, 3) == 0) begin
            put_id(32'($urandom)); put32($urandom_range(0, 5)); put_rand(6);
         end
         len = $urandom_range(0, 12);
         put_id(ID_DATA); put32(len); put_rand(len);
         put_rand($urandom_range(0, 4));
         n = file_bytes.size();
         case ($urandom_range(0, 5))
            0: len = n - $urandom_range(1, 6);
            1: len = n + $urandom_range(0, 20);
            default: len = n;
         endcase
         if (len > n) put_rand(len - n);
         if ($urandom_range(0, 7) == 0)
            foreach (file_bytes[i])
               if ($urandom_range(0, 40) == 0) file_bytes[i] = 8'($urandom);
         send_file(32'(len));
         sent += file_bytes.size();
         if ($urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      int guard;
      errors = 0;
      idle_en = 1'b1;
      parser_clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_errors();
      test_info_list();
      test_data_paths();
      test_random_files(900);
      idle_en = 1'b0;
      test_random_files(300);
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_rsp.size() != 0) report("results left over");
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("wav_riff_chunk_parser_test: done, clean");
      end else begin
         $display("wav_riff_chunk_parser_test: done, errors");
      end
      $finish;
   end

endmodule
